// ----- rtl/erv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erv_pkg
// Shared types, widths and constants of the Euler-angle vector rotator.
// ----------------------------------------------------------------------------
package erv_pkg;

  localparam int CORDIC_STEPS = 24;

  // CORDIC start value: inverse gain * 2^30
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  typedef logic signed [17:0] trig_t;   // sin/cos, scale 2^16, [-65536, 65536]
  typedef logic signed [18:0] ent_t;    // matrix entry, signed Q2.16
  typedef ent_t mat_t [9];              // row-major 3x3

  typedef enum logic [1:0] {
    REG_YAW   = 2'd0,
    REG_PITCH = 2'd1,
    REG_ROLL  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic  done;
    trig_t sin;
    trig_t cos;
  } cordic_rsp_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/euler_rotate_vector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// euler_rotate_vector
// Rotates Q16.16 vectors by the matrix built from yaw, pitch and roll angles.
// ----------------------------------------------------------------------------
// Usage:
//  - Config port: cfg_index_i picks yaw (0), pitch (1) or roll (2); the
//    16 bits of cfg_data_i are the binary angle (65536 = two pi). The port is
//    always ready; other indexes are dropped. Write only while idle.
//  - Each config write, and reset, starts a matrix rebuild: three 24-step
//    CORDIC runs (kick, 24 steps, handoff; one shared unit), 21 products on
//    one multiplier, each a multiply and a store phase, then nine entries at
//    one a cycle. in_stall_o is high while it runs.
//  - Input words (vec_x/y/z_i) are taken when in_valid_i is high and
//    in_stall_o low; one word per cycle while in_stall_o stays low.
//  - From acceptance to out_valid_o a word passes the register stages for
//    products, row sums and saturation, in that order.
//  - When out_stall_i is high the output word holds and the stages behind
//    fill up; in_stall_o rises only once the first stage cannot move.
//  - Reset clears the angles to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module euler_rotate_vector import erv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      rot_x_o,
  output logic signed [31:0]      rot_y_o,
  output logic signed [31:0]      rot_z_o
);

  logic [15:0] yaw_q, pitch_q, roll_q;
  logic        cfg_wr;
  cordic_req_t creq;
  cordic_rsp_t crsp;
  mat_t        mat;
  logic        mat_ok;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
      roll_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_YAW:   yaw_q   <= cfg_data_i;
        REG_PITCH: pitch_q <= cfg_data_i;
        REG_ROLL:  roll_q  <= cfg_data_i;
        default:   yaw_q   <= yaw_q;   // unmapped index
      endcase
    end
  end

  // shared sin/cos unit
  erv_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  // matrix rebuild sequencer
  erv_mat_build u_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .yaw_i     (yaw_q),
    .pitch_i   (pitch_q),
    .roll_i    (roll_q),
    .creq_o    (creq),
    .crsp_i    (crsp),
    .mat_o     (mat),
    .mat_ok_o  (mat_ok)
  );

  // streaming matrix-vector pipeline
  erv_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mat_i       (mat),
    .mat_ok_i    (mat_ok),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o)
  );

endmodule
`default_nettype wire

// ----- rtl/erv_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erv_cordic
// Iterative rotation CORDIC: sine and cosine of a half angle, one step a cycle.
// ----------------------------------------------------------------------------
module erv_cordic import erv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cordic_req_t req_i,
  output cordic_rsp_t      rsp_o
);

  logic              busy_q, done_q, neg_q;
  logic [4:0]        it_q;
  logic signed [32:0] x_q, y_q;
  logic signed [33:0] z_q;

  logic [16:0]       p_fold;
  logic              neg_d;
  logic signed [32:0] xs, ys;
  logic signed [33:0] at;
  trig_t             c_r, s_r;

  // fold the half angle into [0, pi/2]
  always_comb begin
    p_fold = {1'b0, req_i.angle};
    neg_d  = p_fold > 17'd32768;
    if (neg_d) begin
      p_fold = 17'd65536 - p_fold;
    end
  end

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign at = signed'({4'b0, atan_lut(it_q)});

  function automatic trig_t rnd_clamp(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [19:0] r;
    trig_t              o;
    t = 34'(v) + 34'sd8192;
    r = t[33:14];
    if (r > 20'sd65536) begin
      o = 18'sd65536;
    end else if (r < -20'sd65536) begin
      o = -18'sd65536;
    end else begin
      o = r[17:0];
    end
    return o;
  endfunction

  assign c_r = rnd_clamp(x_q);
  assign s_r = rnd_clamp(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == 5'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          it_q <= it_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= CORDIC_X0;
      y_q   <= '0;
      z_q   <= signed'({2'b0, p_fold, 15'b0});
      neg_q <= neg_d;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sin  = s_r;
  assign rsp_o.cos  = neg_q ? -c_r : c_r;

endmodule
`default_nettype wire

// ----- rtl/erv_mat_build.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erv_mat_build
// Sequencer that turns the three angles into the rotation matrix: CORDIC runs,
// quaternion and matrix products on one shared multiplier, then entries.
// ----------------------------------------------------------------------------
module erv_mat_build import erv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        restart_i,
  input  wire logic [15:0] yaw_i,
  input  wire logic [15:0] pitch_i,
  input  wire logic [15:0] roll_i,
  output cordic_req_t      creq_o,
  input  wire cordic_rsp_t crsp_i,
  output mat_t             mat_o,
  output logic             mat_ok_o
);

  typedef enum logic [2:0] {ST_KICK, ST_WAIT, ST_MUL, ST_ENT, ST_DONE} state_e;

  typedef enum logic [4:0] {
    OP_CGCB, OP_SGSB, OP_SGCB, OP_CGSB,
    OP_Q0A, OP_Q0B, OP_Q1A, OP_Q1B, OP_Q2A, OP_Q2B, OP_Q3A, OP_Q3B,
    OP_P22, OP_P33, OP_P12, OP_P03, OP_P02, OP_P13, OP_P11, OP_P01, OP_P23
  } op_e;

  state_e state_q;
  logic [1:0] k_q;
  op_e        op_q;
  logic       ph_q;
  logic [3:0] e_q;

  trig_t s_q [3];
  trig_t c_q [3];
  logic signed [35:0] t_q [4];
  logic signed [50:0] acc_q;
  logic signed [18:0] q_q [4];
  logic signed [37:0] pp_q [9];
  logic signed [54:0] prod_q;
  mat_t m_q;

  logic signed [35:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] qsum, qrnd;
  logic signed [37:0] pa, pb;
  logic               e_neg, e_diag;
  logic signed [39:0] esum;
  logic signed [41:0] ev, et;
  logic signed [25:0] er;
  ent_t               ent;

  // shared multiplier operands; yaw = 0, pitch = 1, roll = 2
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_CGCB: begin mul_a = 36'(c_q[2]); mul_b = 19'(c_q[1]); end
      OP_SGSB: begin mul_a = 36'(s_q[2]); mul_b = 19'(s_q[1]); end
      OP_SGCB: begin mul_a = 36'(s_q[2]); mul_b = 19'(c_q[1]); end
      OP_CGSB: begin mul_a = 36'(c_q[2]); mul_b = 19'(s_q[1]); end
      OP_Q0A:  begin mul_a = t_q[0]; mul_b = 19'(c_q[0]); end
      OP_Q0B:  begin mul_a = t_q[1]; mul_b = 19'(s_q[0]); end
      OP_Q1A:  begin mul_a = t_q[2]; mul_b = 19'(c_q[0]); end
      OP_Q1B:  begin mul_a = t_q[3]; mul_b = 19'(s_q[0]); end
      OP_Q2A:  begin mul_a = t_q[3]; mul_b = 19'(c_q[0]); end
      OP_Q2B:  begin mul_a = t_q[2]; mul_b = 19'(s_q[0]); end
      OP_Q3A:  begin mul_a = t_q[0]; mul_b = 19'(s_q[0]); end
      OP_Q3B:  begin mul_a = t_q[1]; mul_b = 19'(c_q[0]); end
      OP_P22:  begin mul_a = 36'(q_q[2]); mul_b = q_q[2]; end
      OP_P33:  begin mul_a = 36'(q_q[3]); mul_b = q_q[3]; end
      OP_P12:  begin mul_a = 36'(q_q[1]); mul_b = q_q[2]; end
      OP_P03:  begin mul_a = 36'(q_q[0]); mul_b = q_q[3]; end
      OP_P02:  begin mul_a = 36'(q_q[0]); mul_b = q_q[2]; end
      OP_P13:  begin mul_a = 36'(q_q[1]); mul_b = q_q[3]; end
      OP_P11:  begin mul_a = 36'(q_q[1]); mul_b = q_q[1]; end
      OP_P01:  begin mul_a = 36'(q_q[0]); mul_b = q_q[1]; end
      OP_P23:  begin mul_a = 36'(q_q[2]); mul_b = q_q[3]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // second half of a quaternion term, round half up from scale 2^48
  always_comb begin
    if (op_q == OP_Q1B || op_q == OP_Q3B) begin
      qsum = 52'(acc_q) - 52'(signed'(prod_q[50:0]));
    end else begin
      qsum = 52'(acc_q) + 52'(signed'(prod_q[50:0]));
    end
    qrnd = qsum + 52'sd2147483648;
  end

  // matrix entry e: pp index 0 q2q2, 1 q3q3, 2 q1q2, 3 q0q3, 4 q0q2,
  // 5 q1q3, 6 q1q1, 7 q0q1, 8 q2q3
  always_comb begin
    pa = pp_q[0]; pb = pp_q[1]; e_neg = 1'b0; e_diag = 1'b1;
    case (e_q)
      4'd0: begin pa = pp_q[0]; pb = pp_q[1]; e_neg = 1'b0; e_diag = 1'b1; end
      4'd1: begin pa = pp_q[2]; pb = pp_q[3]; e_neg = 1'b1; e_diag = 1'b0; end
      4'd2: begin pa = pp_q[4]; pb = pp_q[5]; e_neg = 1'b0; e_diag = 1'b0; end
      4'd3: begin pa = pp_q[2]; pb = pp_q[3]; e_neg = 1'b0; e_diag = 1'b0; end
      4'd4: begin pa = pp_q[6]; pb = pp_q[1]; e_neg = 1'b0; e_diag = 1'b1; end
      4'd5: begin pa = pp_q[8]; pb = pp_q[7]; e_neg = 1'b1; e_diag = 1'b0; end
      4'd6: begin pa = pp_q[5]; pb = pp_q[4]; e_neg = 1'b1; e_diag = 1'b0; end
      4'd7: begin pa = pp_q[7]; pb = pp_q[8]; e_neg = 1'b0; e_diag = 1'b0; end
      4'd8: begin pa = pp_q[6]; pb = pp_q[0]; e_neg = 1'b0; e_diag = 1'b1; end
      default: begin pa = pp_q[0]; pb = pp_q[1]; e_neg = 1'b0; e_diag = 1'b1; end
    endcase
    esum = e_neg ? (40'(pa) - 40'(pb)) : (40'(pa) + 40'(pb));
    ev   = e_diag ? (42'sd4294967296 - {esum[39], esum, 1'b0})
                  : {esum[39], esum, 1'b0};
    et   = ev + 42'sd32768;
    er   = et[41:16];
    if (er > 26'sd262143) begin
      ent = 19'sd262143;
    end else if (er < -26'sd262144) begin
      ent = -19'sd262144;
    end else begin
      ent = er[18:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_KICK;
      k_q     <= '0;
      op_q    <= OP_CGCB;
      ph_q    <= 1'b0;
      e_q     <= '0;
    end else if (restart_i) begin
      state_q <= ST_KICK;
      k_q     <= '0;
    end else begin
      case (state_q)
        ST_KICK: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (crsp_i.done) begin
            if (k_q == 2'd2) begin
              state_q <= ST_MUL;
              op_q    <= OP_CGCB;
              ph_q    <= 1'b0;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_KICK;
            end
          end
        end
        ST_MUL: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (op_q == OP_P23) begin
              state_q <= ST_ENT;
              e_q     <= '0;
            end else begin
              op_q <= op_e'(op_q + 5'd1);
            end
          end
        end
        ST_ENT: begin
          if (e_q == 4'd8) begin
            state_q <= ST_DONE;
          end else begin
            e_q <= e_q + 4'd1;
          end
        end
        ST_DONE: state_q <= ST_DONE;
        default: state_q <= ST_KICK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && crsp_i.done) begin
      s_q[k_q] <= crsp_i.sin;
      c_q[k_q] <= crsp_i.cos;
    end
    if (state_q == ST_MUL && !ph_q) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_MUL && ph_q) begin
      case (op_q)
        OP_CGCB: t_q[0] <= prod_q[35:0];
        OP_SGSB: t_q[1] <= prod_q[35:0];
        OP_SGCB: t_q[2] <= prod_q[35:0];
        OP_CGSB: t_q[3] <= prod_q[35:0];
        OP_Q0A, OP_Q1A, OP_Q2A, OP_Q3A: acc_q <= prod_q[50:0];
        OP_Q0B: q_q[0] <= qrnd[50:32];
        OP_Q1B: q_q[1] <= qrnd[50:32];
        OP_Q2B: q_q[2] <= qrnd[50:32];
        OP_Q3B: q_q[3] <= qrnd[50:32];
        OP_P22: pp_q[0] <= prod_q[37:0];
        OP_P33: pp_q[1] <= prod_q[37:0];
        OP_P12: pp_q[2] <= prod_q[37:0];
        OP_P03: pp_q[3] <= prod_q[37:0];
        OP_P02: pp_q[4] <= prod_q[37:0];
        OP_P13: pp_q[5] <= prod_q[37:0];
        OP_P11: pp_q[6] <= prod_q[37:0];
        OP_P01: pp_q[7] <= prod_q[37:0];
        OP_P23: pp_q[8] <= prod_q[37:0];
        default: acc_q <= acc_q;
      endcase
    end
    if (state_q == ST_ENT) begin
      m_q[e_q] <= ent;
    end
  end

  always_comb begin
    creq_o.start = (state_q == ST_KICK) && !restart_i;
    case (k_q)
      2'd0:    creq_o.angle = yaw_i;
      2'd1:    creq_o.angle = pitch_i;
      default: creq_o.angle = roll_i;
    endcase
  end

  assign mat_o    = m_q;
  assign mat_ok_o = (state_q == ST_DONE);

endmodule
`default_nettype wire

// ----- rtl/erv_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erv_datapath
// Three-stage matrix-vector pipeline: products, row sums, saturation.
// ----------------------------------------------------------------------------
module erv_datapath import erv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mat_t               mat_i,
  input  wire logic               mat_ok_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      rot_x_o,
  output logic signed [31:0]      rot_y_o,
  output logic signed [31:0]      rot_z_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic signed [31:0] vin [3];
  logic signed [50:0] p1_q [9];
  logic signed [52:0] s2_q [3];
  logic signed [31:0] o3_q [3];
  logic signed [31:0] sat [3];

  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !mat_ok_i || !en1;

  always_comb begin
    logic signed [36:0] r;
    for (int i = 0; i < 3; i++) begin
      r = s2_q[i][52:16];
      if (r > 37'sd2147483647) begin
        sat[i] = 32'sh7fffffff;
      end else if (r < -37'sd2147483648) begin
        sat[i] = 32'sh80000000;
      end else begin
        sat[i] = r[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i && mat_ok_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 9; i++) begin
        p1_q[i] <= vin[i % 3] * mat_i[i];
      end
    end
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        s2_q[r] <= 53'(p1_q[3*r]) + 53'(p1_q[3*r+1]) + 53'(p1_q[3*r+2]) + 53'sd32768;
      end
    end
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        o3_q[r] <= sat[r];
      end
    end
  end

  assign out_valid_o = v3_q;
  assign rot_x_o     = o3_q[0];
  assign rot_y_o     = o3_q[1];
  assign rot_z_o     = o3_q[2];

endmodule
`default_nettype wire

// ----- rtl/erv_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erv_checker
// Port-level checks of the rotator, bound to the top level.
// ----------------------------------------------------------------------------
module erv_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic signed [31:0] vec_x_i,
  input wire logic signed [31:0] vec_y_i,
  input wire logic signed [31:0] vec_z_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] rot_x_o,
  input wire logic signed [31:0] rot_y_o,
  input wire logic signed [31:0] rot_z_o
);

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rot_x_o) && $stable(rot_y_o) && $stable(rot_z_o))
    else $error("output word changed under stall");

  // config write starts a rebuild, input is held off
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("input taken during matrix rebuild");

  // zero vector comes out as zero when the output is not stalled
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i &&
     vec_x_i == 32'sd0 && vec_y_i == 32'sd0 && vec_z_i == 32'sd0)
    ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o && rot_x_o == 32'sd0 && rot_y_o == 32'sd0 && rot_z_o == 32'sd0)
    else $error("zero vector not mapped to zero at fixed latency");

endmodule

bind euler_rotate_vector erv_checker u_erv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .vec_x_i     (vec_x_i),
  .vec_y_i     (vec_y_i),
  .vec_z_i     (vec_z_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .rot_x_o     (rot_x_o),
  .rot_y_o     (rot_y_o),
  .rot_z_o     (rot_z_o)
);
`default_nettype wire

// ----- tb/tb_euler_rotate_vector.sv -----
// ----------------------------------------------------------------------------
// tb_euler_rotate_vector
// Self-checking bench for the Euler-angle vector rotator. The angle registers
// are set through the config port, vectors are streamed in, and each rotated
// word is compared against a bit-true fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_euler_rotate_vector;
  import erv_pkg::*;

  localparam int          WATCHDOG_CYCLES = 4000;
  localparam int          HOLD_CYCLES     = 80;
  localparam logic [1:0]  IDX_UNUSED      = 2'd3;   // no register behind it
  localparam logic signed [31:0] S32_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN  = 32'sh80000000;

  // atan(2^-i), 2^32 per turn
  localparam longint ATAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // ---------------------------------------------------------------- DUT I/O
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] vec_x_i = '0;
  logic signed [31:0] vec_y_i = '0;
  logic signed [31:0] vec_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] rot_x_o;
  logic signed [31:0] rot_y_o;
  logic signed [31:0] rot_z_o;

  euler_rotate_vector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- bench state
  logic [15:0] yaw_q = '0, pitch_q = '0, roll_q = '0;   // predictor copy of regs
  longint      rot_mat [9];                             // predictor matrix, Q2.16
  vec_t        rotated_q [$];                           // words still to come

  int  n_errors   = 0;
  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_cfg      = 0;
  int  idle_cnt   = 0;
  int  stall_pct  = 0;        // receiver stall probability, percent
  bit  gap_en     = 1'b0;     // sender bursts with gaps
  int  burst_left = 0;
  bit  hold_req   = 1'b0;     // ask receiver for a long hold-off
  int  hold_cnt   = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;   // round half up, floor shift
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // sin/cos of angle*pi/65536 (the half angle), scale 2^16
  task automatic half_trig(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, nx;
    int unsigned p;
    bit flip;
    p = ang;
    flip = 1'b0;
    if (p > 32768) begin
      p = 65536 - p;     // fold past pi/2, cosine changes sign
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = longint'(p) <<< 15;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_STEP[i];
      end
      x = nx;
    end
    x = clip(rnd_shift(x, 14), -65536, 65536);
    y = clip(rnd_shift(y, 14), -65536, 65536);
    c = flip ? -x : x;
    s = y;
  endtask

  function automatic longint to_entry(input longint v);
    return clip(rnd_shift(v, 16), -262144, 262143);
  endfunction

  task automatic rebuild_matrix();
    longint sa, ca, sb, cb, sg, cg, q0, q1, q2, q3, one;
    one = 64'sd1 <<< 32;
    half_trig(yaw_q, sa, ca);
    half_trig(pitch_q, sb, cb);
    half_trig(roll_q, sg, cg);
    q0 = rnd_shift(cg * cb * ca + sg * sb * sa, 32);
    q1 = rnd_shift(sg * cb * ca - cg * sb * sa, 32);
    q2 = rnd_shift(cg * sb * ca + sg * cb * sa, 32);
    q3 = rnd_shift(cg * cb * sa - sg * sb * ca, 32);
    rot_mat[0] = to_entry(one - 2 * (q2 * q2 + q3 * q3));
    rot_mat[1] = to_entry(2 * (q1 * q2 - q0 * q3));
    rot_mat[2] = to_entry(2 * (q0 * q2 + q1 * q3));
    rot_mat[3] = to_entry(2 * (q1 * q2 + q0 * q3));
    rot_mat[4] = to_entry(one - 2 * (q1 * q1 + q3 * q3));
    rot_mat[5] = to_entry(2 * (q2 * q3 - q0 * q1));
    rot_mat[6] = to_entry(2 * (q1 * q3 - q0 * q2));
    rot_mat[7] = to_entry(2 * (q0 * q1 + q2 * q3));
    rot_mat[8] = to_entry(one - 2 * (q1 * q1 + q2 * q2));   // corrected [2][2]
  endtask

  function automatic vec_t rotate(input vec_t v);
    vec_t   r;
    longint acc [3];
    for (int k = 0; k < 3; k++) begin
      acc[k] = longint'(v.x) * rot_mat[3*k] + longint'(v.y) * rot_mat[3*k+1]
             + longint'(v.z) * rot_mat[3*k+2];
      acc[k] = clip(rnd_shift(acc[k], 16), longint'(S32_MIN), longint'(S32_MAX));
    end
    r.x = acc[0][31:0];
    r.y = acc[1][31:0];
    r.z = acc[2][31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- receiver
  // Random stall pattern; on request a long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt    <= 0;
    end else if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else if (hold_req) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      hold_req    <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- checker
  // Signals read here are the values from before the edge.
  always @(posedge clk_i) begin
    vec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (rotated_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected output word x=%0d y=%0d z=%0d",
                 $time, rot_x_o, rot_y_o, rot_z_o);
      end else begin
        want = rotated_q.pop_front();
        if (rot_x_o !== want.x) begin
          n_errors++;
          $display("%0t: rot_x expected %0d actual %0d", $time, want.x, rot_x_o);
        end
        if (rot_y_o !== want.y) begin
          n_errors++;
          $display("%0t: rot_y expected %0d actual %0d", $time, want.y, rot_y_o);
        end
        if (rot_z_o !== want.z) begin
          n_errors++;
          $display("%0t: rot_z expected %0d actual %0d", $time, want.z, rot_z_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time, rotated_q.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------- drivers
  // All tasks start and end just after a rising edge.
  task automatic wait_drained();
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);   // pipeline is three stages deep
  endtask

  // Leaves cfg_valid_i high; the caller drops it after its last write.
  task automatic write_angle(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_cfg++;
    case (idx)
      REG_YAW:   yaw_q   = val;
      REG_PITCH: pitch_q = val;
      REG_ROLL:  roll_q  = val;
      default: ;                  // unused index, dropped
    endcase
    rebuild_matrix();
  endtask

  task automatic set_angles(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] g);
    wait_drained();
    write_angle(REG_YAW, a);
    write_angle(REG_PITCH, b);
    write_angle(REG_ROLL, g);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one word, hold it until taken, then maybe open a gap.
  task automatic send_vec(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    in_valid_i <= 1'b1;
    vec_x_i    <= x;
    vec_y_i    <= y;
    vec_z_i    <= z;
    do @(posedge clk_i); while (in_stall_o);
    rotated_q.push_back(rotate(v));
    n_sent++;
    if (gap_en) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(9))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2, 3:    return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  // Zero angles after reset: identity matrix.
  task automatic test_reset_identity();
    send_vec(32'sh00010000, 32'sh00020000, -32'sh00030000);
    send_vec(S32_MAX, S32_MIN, 32'sd0);
    send_vec(32'sd0, 32'sd0, 32'sd0);
    send_vec(-32'sd1, 32'sd1, S32_MAX);
    stop_sending();
  endtask

  // Angle extremes: quarter, half, fold point and the top code.
  task automatic test_extreme_angles();
    set_angles(16'd16384, 16'd0, 16'd0);
    send_vec(32'sh00010000, 32'sh00000000, 32'sh00000000);
    send_vec(32'sh00000000, 32'sh00010000, 32'sh00010000);
    stop_sending();
    set_angles(16'd32768, 16'd32769, 16'd65535);
    send_vec(32'sh00010000, 32'sh00020000, 32'sh00030000);
    send_vec(S32_MIN, S32_MAX, S32_MIN);
    stop_sending();
    set_angles(16'd65535, 16'd65535, 16'd65535);
    send_vec(32'sh12345678, -32'sh0abcdef0, 32'sh7fff0000);
    send_vec(32'sh00010000, 32'sh00010000, 32'sh00010000);
    stop_sending();
    set_angles(16'd0, 16'd16384, 16'd49152);
    send_vec(32'sh00010000, 32'sh00000000, 32'sh00000000);
    send_vec(32'sh00000000, 32'sh00000000, 32'sh00010000);
    stop_sending();
  endtask

  // A write to the unused index must leave all angles alone.
  task automatic test_unused_index();
    wait_drained();
    write_angle(IDX_UNUSED, 16'hffff);
    cfg_valid_i <= 1'b0;
    send_vec(32'sh00010000, 32'sh00020000, 32'sh00030000);
    send_vec(-32'sh00050000, 32'sh00000001, S32_MAX);
    stop_sending();
  endtask

  // Sums past the 32-bit range saturate both ways.
  task automatic test_saturation();
    set_angles(16'd8192, 16'd8192, 16'd0);
    send_vec(S32_MAX, S32_MAX, S32_MAX);
    send_vec(S32_MIN, S32_MIN, S32_MIN);
    send_vec(S32_MAX, S32_MIN, S32_MAX);
    stop_sending();
  endtask

  // Receiver holds off a long time while words keep coming.
  task automatic test_backpressure();
    set_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
    gap_en    = 1'b0;
    stall_pct = 0;
    hold_req <= 1'b1;
    repeat (40) send_vec(rand_comp(), rand_comp(), rand_comp());
    stop_sending();
  endtask

  // Random angle sets with random vectors, varied idling.
  task automatic test_random(input int n_phases, input int per_phase);
    for (int ph = 0; ph < n_phases; ph++) begin
      case (ph % 4)
        0: set_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
        1: set_angles(16'($urandom_range(0, 3) * 16384), 16'($urandom()), 16'd0);
        2: set_angles(16'(16'd65535 - $urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'(16'd32768 + $urandom_range(0, 2)));
        default: set_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
      endcase
      case (ph % 3)
        0: begin gap_en = 1'b0; stall_pct = 0;  end   // full rate, no idling
        1: begin gap_en = 1'b1; stall_pct = 25; end
        default: begin gap_en = 1'b1; stall_pct = 60; end
      endcase
      repeat (per_phase) send_vec(rand_comp(), rand_comp(), rand_comp());
      stop_sending();
    end
    gap_en    = 1'b0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int guard;
    rebuild_matrix();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_extreme_angles();
    test_unused_index();
    test_saturation();
    test_backpressure();
    test_random(9, 100);

    guard = 0;
    while (rotated_q.size() != 0 && guard < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);

    $display("Covered %0d vectors over %0d config writes, %0d words checked,",
             n_sent, n_cfg, n_checked);
    $display("with angle extremes, saturation, an unused index and a long hold-off.");
    if (n_errors == 0 && rotated_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d words never arrived", n_errors, rotated_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/erv_pkg.sv
rtl/erv_cordic.sv
rtl/erv_mat_build.sv
rtl/erv_datapath.sv
rtl/euler_rotate_vector.sv
rtl/erv_checker.sv
tb/tb_euler_rotate_vector.sv
